/* hw/rtl/satc_pkg.sv */
`default_nettype none

package satc_pkg;

    localparam int MAX_ACTORS    = 4096;
    localparam int FRACTION_BITS = 16;

    // group sizes and actor counts run up to MAX_ACTORS
    localparam int GROUP_W = $clog2(MAX_ACTORS + 1);
    // count plus the optional extra one
    localparam int COUNT_W = GROUP_W + 1;
    // quotient of (count << FRACTION_BITS) / divisor
    localparam int QUO_W   = COUNT_W + FRACTION_BITS;
    // radicand for the root, padded to an even width
    localparam int RAD_W   = QUO_W + FRACTION_BITS;
    localparam int RAD_WE  = RAD_W + (RAD_W % 2);
    localparam int ROOT_W  = RAD_WE / 2;
    localparam int SREM_W  = ROOT_W + 2;

    localparam int VALUE_W = 32;
    localparam int COV_W   = 32;
    localparam int DATA_W  = 32;

    localparam int WIDE_A  = (QUO_W > ROOT_W) ? QUO_W : ROOT_W;
    localparam int WIDE_W  = (WIDE_A > VALUE_W) ? WIDE_A : VALUE_W + 1;
    localparam int STEP_W  = $clog2(WIDE_A);

    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
    localparam int IDX_W    = ADDR_W - 2;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_SENDER = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_code_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SAME_VALUE      = IDX_W'(0),
        REG_SAME_VARIABLE   = IDX_W'(1),
        REG_EXCLUDE_MISSING = IDX_W'(2),
        REG_AVERAGE_MODE    = IDX_W'(3),
        REG_ROOT_MODE       = IDX_W'(4),
        REG_ACTOR_COUNT     = IDX_W'(5)
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_FIXED,
        KIND_DIVIDE,
        KIND_PLAIN
    } kind_t;

    typedef struct packed {
        logic               same_value;
        logic               same_variable;
        logic               exclude_missing;
        logic               average_mode;
        logic               root_mode;
        logic [GROUP_W-1:0] actor_count;
    } cfg_t;

    typedef struct packed {
        logic begin_load;
        logic sender_count;
        logic finish_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic emit;
    } ctl_t;

    typedef struct packed {
        kind_t kind;
        logic  last;
    } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/same_attribute_in_tie_count_unit.sv */
// Same-attribute in-tie count. A begin transfer latches ego's covariate, missing flag,
// group size and tie flag and clears the count; each sender transfer compares the
// sender's Q16.16 covariate with ego's and may add one; a finish transfer emits the
// statistic as unsigned Q16.16 with a divide-by-zero flag. Begin and sender transfers
// are taken back to back while no finish is in progress. A finish transfer holds the
// command channel off while the result is built: during the division when the count is
// divided (one quotient bit per cycle from the restoring divider), during the root when
// it is taken (a load step, then one root bit per cycle) and while the output register
// is loaded; a finish that completes while the previous result still waits in the output
// register holds the channel until that result is taken. Begin and sender transfers
// are taken while a result waits in the output register. Registers on the APB port:
// same_value (0x00), same_variable (0x04), exclude_missing (0x08), average_mode (0x0c),
// root_mode (0x10), actor_count (0x14); write them only while no query is in flight.
`default_nettype none

module same_attribute_in_tie_count_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [satc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic        [satc_pkg::DATA_W-1:0]  pwdata,
    output logic             [satc_pkg::DATA_W-1:0]  prdata,
    output logic                                     pready,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire logic        [1:0]                   command,
    input  wire logic signed [satc_pkg::COV_W-1:0]   ego_value,
    input  wire logic                                ego_missing,
    input  wire logic        [satc_pkg::GROUP_W-1:0] ego_group_size,
    input  wire logic                                ego_tie_to_alter,
    input  wire logic signed [satc_pkg::COV_W-1:0]   sender_value,
    input  wire logic                                sender_missing,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output logic             [satc_pkg::VALUE_W-1:0] result_value,
    output logic                                     divide_by_zero
);

    satc_pkg::cfg_t cfg;
    satc_pkg::ctl_t ctl;
    satc_pkg::sts_t sts;

    satc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    satc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    satc_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .ctl              (ctl),
        .sts              (sts),
        .ego_value        (ego_value),
        .ego_missing      (ego_missing),
        .ego_group_size   (ego_group_size),
        .ego_tie_to_alter (ego_tie_to_alter),
        .sender_value     (sender_value),
        .sender_missing   (sender_missing),
        .result_value     (result_value),
        .divide_by_zero   (divide_by_zero)
    );

endmodule

`default_nettype wire

/* hw/rtl/satc_regs.sv */
`default_nettype none

module satc_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [satc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [satc_pkg::DATA_W-1:0]   pwdata,
    output logic      [satc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output satc_pkg::cfg_t                     cfg
);

    satc_pkg::cfg_t                   cfg_reg;
    logic                             wr_en;
    logic [satc_pkg::IDX_W-1:0]       idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[satc_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{same_value: 1'b1, default: '0};
        end
        else if (wr_en)
        begin
            unique case (idx)
                satc_pkg::REG_SAME_VALUE:      cfg_reg.same_value      <= pwdata[0];
                satc_pkg::REG_SAME_VARIABLE:   cfg_reg.same_variable   <= pwdata[0];
                satc_pkg::REG_EXCLUDE_MISSING: cfg_reg.exclude_missing <= pwdata[0];
                satc_pkg::REG_AVERAGE_MODE:    cfg_reg.average_mode    <= pwdata[0];
                satc_pkg::REG_ROOT_MODE:       cfg_reg.root_mode       <= pwdata[0];
                satc_pkg::REG_ACTOR_COUNT:
                    cfg_reg.actor_count <= pwdata[satc_pkg::GROUP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            satc_pkg::REG_SAME_VALUE:      prdata = satc_pkg::DATA_W'(cfg_reg.same_value);
            satc_pkg::REG_SAME_VARIABLE:   prdata = satc_pkg::DATA_W'(cfg_reg.same_variable);
            satc_pkg::REG_EXCLUDE_MISSING: prdata = satc_pkg::DATA_W'(cfg_reg.exclude_missing);
            satc_pkg::REG_AVERAGE_MODE:    prdata = satc_pkg::DATA_W'(cfg_reg.average_mode);
            satc_pkg::REG_ROOT_MODE:       prdata = satc_pkg::DATA_W'(cfg_reg.root_mode);
            satc_pkg::REG_ACTOR_COUNT:     prdata = satc_pkg::DATA_W'(cfg_reg.actor_count);
            default:                       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/satc_ctrl.sv */
`default_nettype none

module satc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  satc_pkg::cfg_t           cfg,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire logic [1:0]          command,
    output logic                     res_valid,
    input  wire logic                res_ready,
    input  satc_pkg::sts_t           sts,
    output satc_pkg::ctl_t           ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT_PREP,
        ST_ROOT,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   res_valid_reg;
    logic   accept;
    logic   out_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid & cmd_ready;
    assign out_free  = ~res_valid_reg | res_ready;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        satc_pkg::CMD_BEGIN:  ctl.begin_load   = 1'b1;
                        satc_pkg::CMD_SENDER: ctl.sender_count = 1'b1;
                        satc_pkg::CMD_FINISH: ctl.finish_load  = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_DIV:       ctl.div_step  = 1'b1;
            ST_ROOT_PREP: ctl.sqrt_load = 1'b1;
            ST_ROOT:      ctl.sqrt_step = 1'b1;
            ST_OUT:       ctl.emit      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ctl.finish_load)
                    begin
                        unique case (sts.kind)
                            satc_pkg::KIND_DIVIDE: state_reg <= ST_DIV;
                            satc_pkg::KIND_PLAIN:
                                state_reg <= cfg.root_mode ? ST_ROOT_PREP : ST_OUT;
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_DIV:
                begin
                    if (sts.last)
                    begin
                        state_reg <= cfg.root_mode ? ST_ROOT_PREP : ST_OUT;
                    end
                end
                ST_ROOT_PREP: state_reg <= ST_ROOT;
                ST_ROOT:
                begin
                    if (sts.last)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/satc_dpath.sv */
`default_nettype none

module satc_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  satc_pkg::cfg_t                          cfg,
    input  satc_pkg::ctl_t                          ctl,
    output satc_pkg::sts_t                          sts,
    input  wire logic signed [satc_pkg::COV_W-1:0]  ego_value,
    input  wire logic                               ego_missing,
    input  wire logic        [satc_pkg::GROUP_W-1:0] ego_group_size,
    input  wire logic                               ego_tie_to_alter,
    input  wire logic signed [satc_pkg::COV_W-1:0]  sender_value,
    input  wire logic                               sender_missing,
    output logic             [satc_pkg::VALUE_W-1:0] result_value,
    output logic                                    divide_by_zero
);

    localparam int GROUP_W = satc_pkg::GROUP_W;
    localparam int COUNT_W = satc_pkg::COUNT_W;
    localparam int QUO_W   = satc_pkg::QUO_W;
    localparam int RAD_WE  = satc_pkg::RAD_WE;
    localparam int ROOT_W  = satc_pkg::ROOT_W;
    localparam int SREM_W  = satc_pkg::SREM_W;
    localparam int VALUE_W = satc_pkg::VALUE_W;
    localparam int WIDE_W  = satc_pkg::WIDE_W;
    localparam int STEP_W  = satc_pkg::STEP_W;
    localparam int FRAC    = satc_pkg::FRACTION_BITS;

    typedef enum logic [1:0] {
        SRC_FIXED,
        SRC_QUO,
        SRC_ROOT
    } src_t;

    // query state
    logic [GROUP_W-1:0]           match_count_reg;
    logic [satc_pkg::COV_W-1:0]   ego_cov_reg;
    logic                         ego_absent_reg;
    logic [GROUP_W-1:0]           group_size_reg;
    logic                         tie_present_reg;

    // finish unit
    logic [QUO_W-1:0]             quo_reg;
    logic [GROUP_W-1:0]           divisor_reg;
    logic [GROUP_W-1:0]           drem_reg;
    logic [RAD_WE-1:0]            rad_reg;
    logic [ROOT_W-1:0]            root_reg;
    logic [SREM_W-1:0]            srem_reg;
    logic [STEP_W-1:0]            step_reg;
    src_t                         src_reg;
    logic                         fix_sat_reg;

    logic [VALUE_W-1:0]           result_value_reg;
    logic                         dbz_reg;

    // sender compare
    logic                         equal;
    logic                         hit;

    // finish decision
    logic [COUNT_W-1:0]           count;
    logic                         fixed_zero;
    logic                         empty_group;
    logic                         other_pos;
    logic [GROUP_W-1:0]           other_size;
    satc_pkg::kind_t              kind;
    logic [QUO_W-1:0]             dividend_init;

    // divider step
    logic [GROUP_W:0]             dtrial;
    logic                         dge;
    logic [GROUP_W:0]             ddiff;

    // root step
    logic [SREM_W+1:0]            strial;
    logic [SREM_W+1:0]            stest;
    logic                         sge;
    logic [SREM_W+1:0]            sdiff;

    // output select
    logic [WIDE_W-1:0]            wide_val;
    logic                         wide_sat;

    assign equal = (sender_value == ego_cov_reg);
    assign hit   = (cfg.same_value ? equal : ~equal)
                   & ~(cfg.exclude_missing & sender_missing);

    assign count       = COUNT_W'(match_count_reg)
                         + COUNT_W'(cfg.same_value & cfg.same_variable & ~tie_present_reg);
    assign fixed_zero  = cfg.exclude_missing & ego_absent_reg;
    assign empty_group = cfg.average_mode & cfg.same_value & (group_size_reg == '0);
    assign other_pos   = cfg.actor_count > group_size_reg;
    assign other_size  = cfg.actor_count - group_size_reg;

    always_comb
    begin
        priority if (fixed_zero || empty_group)
        begin
            kind = satc_pkg::KIND_FIXED;
        end
        else if (cfg.average_mode && (cfg.same_value || other_pos))
        begin
            kind = satc_pkg::KIND_DIVIDE;
        end
        else
        begin
            kind = satc_pkg::KIND_PLAIN;
        end
    end

    // different-value average with no others gives zero
    assign dividend_init = (cfg.average_mode && !cfg.same_value && !other_pos)
                           ? '0 : {count, {FRAC{1'b0}}};

    assign dtrial = {drem_reg, quo_reg[QUO_W-1]};
    assign dge    = dtrial >= {1'b0, divisor_reg};
    assign ddiff  = dtrial - {1'b0, divisor_reg};

    assign strial = {srem_reg, rad_reg[RAD_WE-1 -: 2]};
    assign stest  = (SREM_W + 2)'({root_reg, 2'b01});
    assign sge    = strial >= stest;
    assign sdiff  = strial - stest;

    assign wide_val = (src_reg == SRC_ROOT) ? WIDE_W'(root_reg) : WIDE_W'(quo_reg);
    assign wide_sat = |wide_val[WIDE_W-1:VALUE_W];

    assign sts.kind = kind;
    assign sts.last = (step_reg == '0);

    assign result_value   = result_value_reg;
    assign divide_by_zero = dbz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg <= '0;
            ego_cov_reg     <= '0;
            ego_absent_reg  <= 1'b0;
            group_size_reg  <= '0;
            tie_present_reg <= 1'b0;
        end
        else if (ctl.begin_load)
        begin
            match_count_reg <= '0;
            ego_cov_reg     <= ego_value;
            ego_absent_reg  <= ego_missing;
            group_size_reg  <= ego_group_size;
            tie_present_reg <= ego_tie_to_alter;
        end
        else if (ctl.sender_count && hit && (match_count_reg != '1))
        begin
            match_count_reg <= match_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            src_reg  <= SRC_FIXED;
        end
        else if (ctl.finish_load)
        begin
            step_reg <= STEP_W'(QUO_W - 1);
            src_reg  <= (kind == satc_pkg::KIND_FIXED) ? SRC_FIXED : SRC_QUO;
        end
        else if (ctl.sqrt_load)
        begin
            step_reg <= STEP_W'(ROOT_W - 1);
            src_reg  <= SRC_ROOT;
        end
        else if ((ctl.div_step || ctl.sqrt_step) && (step_reg != '0))
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    // restoring divider and digit-by-digit root, one bit per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.finish_load)
        begin
            quo_reg     <= dividend_init;
            divisor_reg <= cfg.same_value ? group_size_reg : other_size;
            drem_reg    <= '0;
            fix_sat_reg <= empty_group & ~fixed_zero;
        end
        else if (ctl.div_step)
        begin
            quo_reg  <= {quo_reg[QUO_W-2:0], dge};
            drem_reg <= dge ? ddiff[GROUP_W-1:0] : dtrial[GROUP_W-1:0];
        end

        if (ctl.sqrt_load)
        begin
            rad_reg  <= RAD_WE'({quo_reg, {FRAC{1'b0}}});
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (ctl.sqrt_step)
        begin
            rad_reg  <= {rad_reg[RAD_WE-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], sge};
            srem_reg <= sge ? sdiff[SREM_W-1:0] : strial[SREM_W-1:0];
        end

        if (ctl.emit)
        begin
            if (src_reg == SRC_FIXED)
            begin
                result_value_reg <= fix_sat_reg ? '1 : '0;
                dbz_reg          <= fix_sat_reg;
            end
            else
            begin
                result_value_reg <= wide_sat ? '1 : wide_val[VALUE_W-1:0];
                dbz_reg          <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/satc_checker.sv */
`default_nettype none

module satc_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                cmd_valid,
    input wire logic                                cmd_ready,
    input wire logic [1:0]                          command,
    input wire logic                                res_valid,
    input wire logic                                res_ready,
    input wire logic [satc_pkg::VALUE_W-1:0]        result_value,
    input wire logic                                divide_by_zero
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_value)
            && $stable(divide_by_zero))
        else $error("result changed while stalled");

    // a divide-by-zero flag always comes with a saturated value
    a_dbz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && divide_by_zero |-> result_value == '1)
        else $error("divide_by_zero without saturated value");

    // a finish transfer blocks the command channel while the result is built
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (command == satc_pkg::CMD_FINISH) |=> !cmd_ready)
        else $error("command taken while finish in progress");

    // a new result only follows a busy cycle
    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready))
        else $error("result appeared without a finish");

endmodule

bind same_attribute_in_tie_count_unit satc_checker u_satc_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int         COV_W            = satc_pkg::COV_W;
    localparam int         GROUP_W          = satc_pkg::GROUP_W;
    localparam int         VALUE_W          = satc_pkg::VALUE_W;
    localparam int         DATA_W           = satc_pkg::DATA_W;
    localparam int         ADDR_W           = satc_pkg::ADDR_W;
    localparam int         MAX_ACTORS       = satc_pkg::MAX_ACTORS;
    localparam int         FRACTION_BITS    = satc_pkg::FRACTION_BITS;

    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam int         SETTLE_CYCLES    = 64;
    localparam int         LONG_STALL       = 400;
    localparam int         LONG_RUN_SENDERS = 200;
    localparam int         EPOCHS           = 12;
    localparam int         EPOCH_ITEMS      = 120;
    localparam int         MAX_PRINTED      = 100;

    typedef struct packed {
        logic [1:0]         command;
        logic [COV_W-1:0]   ego_value;
        logic               ego_missing;
        logic [GROUP_W-1:0] ego_group_size;
        logic               ego_tie_to_alter;
        logic [COV_W-1:0]   sender_value;
        logic               sender_missing;
    } query_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               flag;
    } statistic_t;

    typedef struct {
        bit                 is_cfg;
        satc_pkg::reg_idx_t reg_sel;
        logic [DATA_W-1:0]  reg_val;
        query_item_t        item;
        bit                 typed;
        statistic_t         want;
    } script_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      cmd_valid;
    logic                      cmd_ready;
    logic [1:0]                command;
    logic signed [COV_W-1:0]   ego_value;
    logic                      ego_missing;
    logic [GROUP_W-1:0]        ego_group_size;
    logic                      ego_tie_to_alter;
    logic signed [COV_W-1:0]   sender_value;
    logic                      sender_missing;
    logic                      res_valid;
    logic                      res_ready;
    logic [VALUE_W-1:0]        result_value;
    logic                      divide_by_zero;

    // predictor state
    satc_pkg::cfg_t     cfg;
    logic [GROUP_W-1:0] match_tally = '0;
    logic [COV_W-1:0]   ego_cov     = '0;
    logic               ego_gone    = 1'b0;
    logic [GROUP_W-1:0] ego_group   = '0;
    logic               ego_tied    = 1'b0;

    statistic_t expected_stats[$];
    int         errors = 0;
    int         items_sent = 0;
    int         snd_idle = 33;
    int         rcv_idle = 64;
    bit         long_stall_pending = 1'b0;
    bit         typed_now = 1'b0;
    statistic_t typed_want = '0;

    same_attribute_in_tie_count_unit dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic statistic_t in_tie_statistic();
        statistic_t      s;
        longint unsigned num;
        longint unsigned val;
        s = '0;
        if (cfg.exclude_missing && ego_gone)
            return s;
        num = match_tally;
        if (cfg.same_value && cfg.same_variable && !ego_tied)
            num++;
        if (!cfg.average_mode)
            val = num << FRACTION_BITS;
        else if (cfg.same_value)
        begin
            if (ego_group == 0)
            begin
                s.value = '1;
                s.flag  = 1'b1;
                return s;
            end
            val = (num << FRACTION_BITS) / ego_group;
        end
        else if (cfg.actor_count > ego_group)
            val = (num << FRACTION_BITS) / (cfg.actor_count - ego_group);
        else
            val = 0;
        if (cfg.root_mode)
            val = int_sqrt(val << FRACTION_BITS);
        s.value = (val > 64'hFFFF_FFFF) ? '1 : val[VALUE_W-1:0];
        return s;
    endfunction

    // both channels sampled before the edge updates land
    always @(posedge clk)
    begin : monitor
        statistic_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_stats.size() == 0)
                    report_mismatch($sformatf("result %h flag %b with no finish pending",
                                              result_value, divide_by_zero));
                else
                begin
                    want = expected_stats.pop_front();
                    if (result_value !== want.value)
                        report_mismatch($sformatf("result_value %h, want %h",
                                                  result_value, want.value));
                    if (divide_by_zero !== want.flag)
                        report_mismatch($sformatf("divide_by_zero %b, want %b",
                                                  divide_by_zero, want.flag));
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                case (command)
                    satc_pkg::CMD_BEGIN:
                    begin
                        ego_cov     = ego_value;
                        ego_gone    = ego_missing;
                        ego_group   = ego_group_size;
                        ego_tied    = ego_tie_to_alter;
                        match_tally = '0;
                    end
                    satc_pkg::CMD_SENDER:
                        if (!(cfg.exclude_missing && sender_missing) &&
                            (cfg.same_value == (sender_value == ego_cov)) &&
                            match_tally != '1)
                            match_tally = match_tally + 1'b1;
                    satc_pkg::CMD_FINISH:
                        expected_stats.push_back(typed_now ? typed_want : in_tie_statistic());
                    default: ;
                endcase
            end
        end
    end

    // receiver, with one long hold-off on request
    initial
    begin : receiver
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall_pending)
            begin
                long_stall_pending = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            res_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic offer(input query_item_t it, input bit typed = 1'b0,
                         input statistic_t want = '0);
        while ($urandom_range(99) < snd_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid        <= 1'b1;
        command          <= it.command;
        ego_value        <= it.ego_value;
        ego_missing      <= it.ego_missing;
        ego_group_size   <= it.ego_group_size;
        ego_tie_to_alter <= it.ego_tie_to_alter;
        sender_value     <= it.sender_value;
        sender_missing   <= it.sender_missing;
        typed_now        <= typed;
        typed_want       <= want;
        do
            @(posedge clk);
        while (!cmd_ready);
        items_sent++;
    endtask

    // let every pending result drain, then give a trailing finish time to complete
    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input satc_pkg::reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            satc_pkg::REG_SAME_VALUE:      cfg.same_value      = value[0];
            satc_pkg::REG_SAME_VARIABLE:   cfg.same_variable   = value[0];
            satc_pkg::REG_EXCLUDE_MISSING: cfg.exclude_missing = value[0];
            satc_pkg::REG_AVERAGE_MODE:    cfg.average_mode    = value[0];
            satc_pkg::REG_ROOT_MODE:       cfg.root_mode       = value[0];
            satc_pkg::REG_ACTOR_COUNT:     cfg.actor_count     = value[GROUP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(input logic sv, svar, excl, avg, root,
                                 input logic [GROUP_W-1:0] actors);
        write_reg(satc_pkg::REG_SAME_VALUE, DATA_W'(sv));
        write_reg(satc_pkg::REG_SAME_VARIABLE, DATA_W'(svar));
        write_reg(satc_pkg::REG_EXCLUDE_MISSING, DATA_W'(excl));
        write_reg(satc_pkg::REG_AVERAGE_MODE, DATA_W'(avg));
        write_reg(satc_pkg::REG_ROOT_MODE, DATA_W'(root));
        write_reg(satc_pkg::REG_ACTOR_COUNT, DATA_W'(actors));
    endtask

    function automatic logic [GROUP_W-1:0] pick_size();
        case ($urandom_range(19))
            0, 1, 2:    return '0;
            3:          return GROUP_W'(MAX_ACTORS);
            4, 5, 6, 7: return GROUP_W'($urandom_range(MAX_ACTORS));
            default:    return GROUP_W'($urandom_range(12, 1));
        endcase
    endfunction

    function automatic logic [COV_W-1:0] pick_cov();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic query_item_t random_item();
        query_item_t it;
        it.command          = 2'($urandom_range(3));
        it.ego_value        = pick_cov();
        it.ego_missing      = 1'($urandom_range(1));
        it.ego_group_size   = pick_size();
        it.ego_tie_to_alter = 1'($urandom_range(1));
        it.sender_value     = pick_cov();
        it.sender_missing   = 1'($urandom_range(1));
        return it;
    endfunction

    // begin, a run of senders, finish; now and then a stray command breaks the run
    task automatic random_query();
        query_item_t        it;
        logic [COV_W-1:0]   ego;
        int unsigned        senders;
        it = random_item();
        it.command = satc_pkg::CMD_BEGIN;
        ego = it.ego_value;
        offer(it);
        senders = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        repeat (senders)
        begin
            it = random_item();
            if ($urandom_range(14) != 0)
            begin
                it.command = satc_pkg::CMD_SENDER;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: it.sender_value = ego;
                    5, 6:          it.sender_value = ego ^ (32'd1 << $urandom_range(31));
                    default: ;
                endcase
            end
            offer(it);
        end
        it = random_item();
        it.command = satc_pkg::CMD_FINISH;
        offer(it);
        if ($urandom_range(9) == 0)
            offer(it);
    endtask

    function automatic script_row_t cfg_row(input satc_pkg::reg_idx_t idx,
                                            input logic [DATA_W-1:0] value);
        script_row_t r;
        r = '{reg_sel: satc_pkg::REG_SAME_VALUE, default: '0};
        r.is_cfg  = 1'b1;
        r.reg_sel = idx;
        r.reg_val = value;
        return r;
    endfunction

    function automatic script_row_t cmd_row(input logic [1:0] cmd, input logic [COV_W-1:0] cov,
                                            input logic miss,
                                            input logic [GROUP_W-1:0] size = '0,
                                            input logic tie = 1'b0);
        script_row_t r;
        r = '{reg_sel: satc_pkg::REG_SAME_VALUE, default: '0};
        r.item.command          = cmd;
        r.item.ego_value        = cov;
        r.item.ego_missing      = miss;
        r.item.ego_group_size   = size;
        r.item.ego_tie_to_alter = tie;
        r.item.sender_value     = cov;
        r.item.sender_missing   = miss;
        return r;
    endfunction

    function automatic script_row_t finish_row(input bit typed,
                                               input logic [VALUE_W-1:0] value = '0,
                                               input logic flag = 1'b0);
        script_row_t r;
        r = '{reg_sel: satc_pkg::REG_SAME_VALUE, default: '0};
        r.item.command = satc_pkg::CMD_FINISH;
        r.typed        = typed;
        r.want.value   = value;
        r.want.flag    = flag;
        return r;
    endfunction

    initial
    begin : stimulus
        script_row_t script[$];
        query_item_t it;
        int          epoch;
        int          quota;

        cfg = '0;
        cfg.same_value   = 1'b1;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_valid        = 1'b0;
        command          = satc_pkg::CMD_BEGIN;
        ego_value        = '0;
        ego_missing      = 1'b0;
        ego_group_size   = '0;
        ego_tie_to_alter = 1'b0;
        sender_value     = '0;
        sender_missing   = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // finish straight after reset sees cleared state
        script.push_back(finish_row(1'b1, 32'h0000_0000, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_BEGIN, 32'h7FFF_FFFF, 1'b0,
                                 GROUP_W'(MAX_ACTORS), 1'b1));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h7FFF_FFFF, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h8000_0000, 1'b1));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h7FFF_FFFF, 1'b1));
        script.push_back(cmd_row(CMD_UNUSED, 32'h7FFF_FFFF, 1'b0, '0, 1'b0));
        script.push_back(finish_row(1'b1, 32'h0002_0000, 1'b0));
        // a second finish reuses the same state
        script.push_back(finish_row(1'b1, 32'h0002_0000, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_BEGIN, 32'h8000_0000, 1'b1, '0, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h8000_0000, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h8000_0001, 1'b0));
        script.push_back(finish_row(1'b1, 32'h0001_0000, 1'b0));
        // empty group under averaging, with and without the root
        script.push_back(cfg_row(satc_pkg::REG_AVERAGE_MODE, 32'd1));
        script.push_back(finish_row(1'b1, 32'hFFFF_FFFF, 1'b1));
        script.push_back(cfg_row(satc_pkg::REG_ROOT_MODE, 32'd1));
        script.push_back(finish_row(1'b1, 32'hFFFF_FFFF, 1'b1));
        // missing ego under exclusion
        script.push_back(cfg_row(satc_pkg::REG_EXCLUDE_MISSING, 32'd1));
        script.push_back(finish_row(1'b1, 32'h0000_0000, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_BEGIN, 32'h0001_0000, 1'b0, GROUP_W'(3), 1'b0));
        script.push_back(cfg_row(satc_pkg::REG_SAME_VARIABLE, 32'd1));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h0001_0000, 1'b1));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h0001_0000, 1'b0));
        script.push_back(finish_row(1'b0));
        // different-value mode, divisor not positive and then one
        script.push_back(cfg_row(satc_pkg::REG_SAME_VALUE, 32'd0));
        script.push_back(cfg_row(satc_pkg::REG_ACTOR_COUNT, MAX_ACTORS));
        script.push_back(cmd_row(satc_pkg::CMD_BEGIN, 32'h0000_0000, 1'b0,
                                 GROUP_W'(MAX_ACTORS), 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h0000_0001, 1'b0));
        script.push_back(finish_row(1'b1, 32'h0000_0000, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_BEGIN, 32'hFFFF_FFFF, 1'b0,
                                 GROUP_W'(MAX_ACTORS - 1), 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'hFFFF_FFFF, 1'b0));
        script.push_back(cmd_row(satc_pkg::CMD_SENDER, 32'h0000_0000, 1'b0));
        script.push_back(finish_row(1'b0));

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                write_reg(script[i].reg_sel, script[i].reg_val);
            end
            else
                offer(script[i].item, script[i].typed, script[i].want);
        end

        // a long run of matching senders back to back
        settle();
        snd_idle = 0;
        rcv_idle = 0;
        load_settings(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, pick_size());
        it = random_item();
        it.command = satc_pkg::CMD_BEGIN;
        it.ego_tie_to_alter = 1'b0;
        offer(it);
        repeat (LONG_RUN_SENDERS)
        begin
            it.command = satc_pkg::CMD_SENDER;
            it.sender_value = it.ego_value;
            it.sender_missing = 1'($urandom_range(1));
            offer(it);
        end
        it.command = satc_pkg::CMD_FINISH;
        offer(it);

        for (epoch = 0; epoch < EPOCHS; epoch++)
        begin
            settle();
            snd_idle = (epoch < 4) ? 33 : (epoch < 8) ? 64 : 0;
            rcv_idle = (epoch < 4) ? 64 : (epoch < 8) ? 33 : 0;
            if (epoch == 0)
                load_settings(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
            else if (epoch == 1)
                load_settings(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, GROUP_W'(MAX_ACTORS));
            else
                load_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), pick_size());
            // receiver holds off while the sender keeps pushing transfers
            if (epoch == 9)
                long_stall_pending = 1'b1;
            quota = items_sent + EPOCH_ITEMS;
            while (items_sent < quota)
                random_query();
        end

        settle();
        if (expected_stats.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_stats.size()));
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
